// ===== src/cidmd_pkg.sv =====
package cidmd_pkg;

    localparam logic [2:0] KIND_NUM_CHAR    = 3'd0;
    localparam logic [2:0] KIND_NAME_CHAR   = 3'd1;
    localparam logic [2:0] KIND_DATE        = 3'd2;
    localparam logic [2:0] KIND_NUM_ABSENT  = 3'd3;
    localparam logic [2:0] KIND_NAME_ABSENT = 3'd4;
    localparam logic [2:0] KIND_DONE        = 3'd5;
    localparam logic [2:0] KIND_BAD_TYPE    = 3'd6;
    localparam logic [2:0] KIND_OVERRUN     = 3'd7;

    localparam logic [7:0] TYPE_SINGLE   = 8'h04;
    localparam logic [7:0] TYPE_MULTI    = 8'h80;
    localparam logic [7:0] PARAM_DATE    = 8'h01;
    localparam logic [7:0] PARAM_NUMBER  = 8'h02;
    localparam logic [7:0] PARAM_NUM_ABS = 8'h04;
    localparam logic [7:0] PARAM_NAME    = 8'h07;
    localparam logic [7:0] PARAM_NAM_ABS = 8'h08;
    localparam logic [7:0] CHAR_O        = 8'h4f;
    localparam logic [7:0] CHAR_P        = 8'h50;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] DATE_DIGITS   = 8'd8;

    localparam logic [1:0] REASON_UNAVAIL = 2'd0;
    localparam logic [1:0] REASON_PRIVATE = 2'd1;
    localparam logic [1:0] REASON_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [2:0]      kind;
        logic [7:0]      char_value;
        logic [7:0][3:0] digits;
        logic            date_valid;
        logic [1:0]      absent_reason;
        logic            checksum_ok;
        logic            multi_format;
    } t_rec;

    function automatic logic [1:0] reason_of(input logic [7:0] b);
        if (b == CHAR_O) begin
            return REASON_UNAVAIL;
        end else if (b == CHAR_P) begin
            return REASON_PRIVATE;
        end
        return REASON_UNKNOWN;
    endfunction

endpackage

// ===== src/cidmd_front.sv =====
module cidmd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_msg_byte,
    input  logic              i_full,
    output logic              o_push,
    output cidmd_pkg::t_rec   o_rec
);
    import cidmd_pkg::*;

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_SDATE = 3'd2;
    localparam logic [2:0] PH_SNUM  = 3'd3;
    localparam logic [2:0] PH_PTYPE = 3'd4;
    localparam logic [2:0] PH_PLEN  = 3'd5;
    localparam logic [2:0] PH_PDATA = 3'd6;
    localparam logic [2:0] PH_CSUM  = 3'd7;

    logic [2:0] r_phase, n_phase;
    logic       r_fmt, n_fmt;
    logic [7:0] r_mleft, n_mleft;
    logic [7:0] r_pkind, n_pkind;
    logic [7:0] r_pleft, n_pleft;
    logic [7:0] r_psize, n_psize;
    logic [7:0] r_sum, n_sum;
    logic [2:0] r_didx, n_didx;
    logic       r_dbad, n_dbad;
    logic [3:0] r_digits [8];

    logic       accept;
    logic [7:0] b;
    logic [7:0] sum_new;
    logic [7:0] ml;
    logic [7:0] pos;
    logic [7:0] pleft_new;
    logic       is_digit;
    logic [3:0] digit;
    logic       dwe;
    logic       overrun;
    t_rec       rec;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign b         = i_msg_byte;
    assign sum_new   = r_sum + b;
    assign ml        = r_mleft - 8'd1;
    assign pos       = r_psize - r_pleft;
    assign pleft_new = r_pleft - 8'd1;
    assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit     = is_digit ? b[3:0] : 4'd0;

    always_comb begin
        n_phase = r_phase;
        n_fmt   = r_fmt;
        n_mleft = r_mleft;
        n_pkind = r_pkind;
        n_pleft = r_pleft;
        n_psize = r_psize;
        n_sum   = r_sum;
        n_didx  = r_didx;
        n_dbad  = r_dbad;
        dwe     = 1'b0;
        overrun = 1'b0;
        o_push  = 1'b0;
        rec              = '0;
        rec.multi_format = r_fmt;
        if (accept) begin
            if (r_phase == PH_WAIT) begin
                if (b == TYPE_SINGLE || b == TYPE_MULTI) begin
                    n_fmt   = (b == TYPE_MULTI);
                    n_sum   = b;
                    n_phase = PH_LEN;
                end else begin
                    o_push           = 1'b1;
                    rec.kind         = KIND_BAD_TYPE;
                    rec.multi_format = 1'b0;
                end
            end else begin
                n_sum = sum_new;
                if (r_phase == PH_CSUM) begin
                    o_push          = 1'b1;
                    rec.kind        = KIND_DONE;
                    rec.checksum_ok = (sum_new == 8'd0);
                    n_phase         = PH_WAIT;
                end else if (r_phase == PH_LEN) begin
                    n_mleft = b;
                    n_didx  = 3'd0;
                    n_dbad  = 1'b0;
                    if (b == 8'd0) begin
                        n_phase = PH_CSUM;
                    end else begin
                        n_phase = r_fmt ? PH_PTYPE : PH_SDATE;
                    end
                end else begin
                    n_mleft = ml;
                    case (r_phase)
                        PH_SDATE: begin
                            dwe = 1'b1;
                            if (r_didx == 3'd7) begin
                                n_phase = PH_SNUM;
                            end
                        end
                        PH_SNUM: begin
                            o_push         = 1'b1;
                            rec.kind       = KIND_NUM_CHAR;
                            rec.char_value = b;
                        end
                        PH_PTYPE: begin
                            n_pkind = b;
                            n_phase = PH_PLEN;
                        end
                        PH_PLEN: begin
                            if (b > ml) begin
                                o_push   = 1'b1;
                                rec.kind = KIND_OVERRUN;
                                n_phase  = PH_WAIT;
                                overrun  = 1'b1;
                            end else begin
                                n_psize = b;
                                n_pleft = b;
                                n_didx  = 3'd0;
                                n_dbad  = 1'b0;
                                n_phase = (b == 8'd0) ? PH_PTYPE : PH_PDATA;
                            end
                        end
                        default: begin
                            n_pleft = pleft_new;
                            case (r_pkind)
                                PARAM_DATE: begin
                                    dwe = (pos < DATE_DIGITS);
                                end
                                PARAM_NUMBER: begin
                                    o_push         = 1'b1;
                                    rec.kind       = KIND_NUM_CHAR;
                                    rec.char_value = b;
                                end
                                PARAM_NUM_ABS, PARAM_NAM_ABS: begin
                                    if (pos == 8'd0) begin
                                        o_push   = 1'b1;
                                        rec.kind = (r_pkind == PARAM_NUM_ABS) ?
                                                   KIND_NUM_ABSENT : KIND_NAME_ABSENT;
                                        rec.absent_reason = reason_of(b);
                                    end
                                end
                                PARAM_NAME: begin
                                    o_push = 1'b1;
                                    if (r_psize == 8'd1 && (b == CHAR_O || b == CHAR_P)) begin
                                        rec.kind          = KIND_NAME_ABSENT;
                                        rec.absent_reason = reason_of(b);
                                    end else begin
                                        rec.kind       = KIND_NAME_CHAR;
                                        rec.char_value = b;
                                    end
                                end
                                default: begin
                                end
                            endcase
                            if (pleft_new == 8'd0) begin
                                n_phase = PH_PTYPE;
                            end
                        end
                    endcase
                    if (dwe) begin
                        n_dbad = r_dbad || !is_digit;
                        n_didx = r_didx + 3'd1;
                        if (r_didx == 3'd7) begin
                            o_push         = 1'b1;
                            rec.kind       = KIND_DATE;
                            rec.date_valid = !(r_dbad || !is_digit);
                            for (int i = 0; i < 7; i++) begin
                                rec.digits[7 - i] = r_digits[i];
                            end
                            rec.digits[0] = digit;
                        end
                    end
                    if (!overrun && ml == 8'd0) begin
                        n_phase = PH_CSUM;
                    end
                end
            end
        end
    end

    assign o_rec = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_fmt   <= 1'b0;
            r_mleft <= 8'd0;
            r_pkind <= 8'd0;
            r_pleft <= 8'd0;
            r_psize <= 8'd0;
            r_sum   <= 8'd0;
            r_didx  <= 3'd0;
            r_dbad  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_fmt   <= n_fmt;
            r_mleft <= n_mleft;
            r_pkind <= n_pkind;
            r_pleft <= n_pleft;
            r_psize <= n_psize;
            r_sum   <= n_sum;
            r_didx  <= n_didx;
            r_dbad  <= n_dbad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dwe) begin
            r_digits[r_didx] <= digit;
        end
    end

endmodule

// ===== src/cidmd_queue.sv =====
module cidmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cidmd_pkg::t_rec   i_rec,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output cidmd_pkg::t_rec   o_rec
);
    import cidmd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== src/cidmd_back.sv =====
module cidmd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_pop,
    input  cidmd_pkg::t_rec   i_rec,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_char_value,
    output logic [6:0]        o_month,
    output logic [6:0]        o_day,
    output logic [6:0]        o_hour,
    output logic [6:0]        o_minute,
    output logic              o_date_valid,
    output logic [1:0]        o_absent_reason,
    output logic              o_checksum_ok,
    output logic              o_multi_format
);
    import cidmd_pkg::*;

    logic       r_valid;
    logic [2:0] r_kind;
    logic [7:0] r_char;
    logic [6:0] r_month, r_day, r_hour, r_minute;
    logic       r_date_valid;
    logic [1:0] r_reason;
    logic       r_csum_ok;
    logic       r_multi;

    function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
        return 7'(hi) * 7'd10 + 7'(lo);
    endfunction

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind       <= i_rec.kind;
            r_char       <= i_rec.char_value;
            r_month      <= two_digits(i_rec.digits[7], i_rec.digits[6]);
            r_day        <= two_digits(i_rec.digits[5], i_rec.digits[4]);
            r_hour       <= two_digits(i_rec.digits[3], i_rec.digits[2]);
            r_minute     <= two_digits(i_rec.digits[1], i_rec.digits[0]);
            r_date_valid <= i_rec.date_valid;
            r_reason     <= i_rec.absent_reason;
            r_csum_ok    <= i_rec.checksum_ok;
            r_multi      <= i_rec.multi_format;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_char_value    = r_char;
    assign o_month         = r_month;
    assign o_day           = r_day;
    assign o_hour          = r_hour;
    assign o_minute        = r_minute;
    assign o_date_valid    = r_date_valid;
    assign o_absent_reason = r_reason;
    assign o_checksum_ok   = r_csum_ok;
    assign o_multi_format  = r_multi;

endmodule

// ===== src/caller_id_message_decoder_top.sv =====
// Channel   Signals                       Word
// input     i_valid / o_ready             i_msg_byte
// output    o_valid / i_ready             o_kind, o_char_value, date, reason, status fields
//
// One byte per cycle is accepted while o_ready is high; each byte yields zero or one result word.
// The parser is combinational and writes the queue at the accepting edge; the output register
// loads the word from the queue when it is empty or i_ready is high, and offers it from there.
// Synchronous reset clears parser state, queue pointers and output valid; result fields do not.
// A stalled output fills the output register and the QUEUE_DEPTH-entry queue, then o_ready
// drops, even for bytes that yield no word, until a word leaves the queue.
module caller_id_message_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_msg_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_char_value,
    output logic [6:0] o_month,
    output logic [6:0] o_day,
    output logic [6:0] o_hour,
    output logic [6:0] o_minute,
    output logic       o_date_valid,
    output logic [1:0] o_absent_reason,
    output logic       o_checksum_ok,
    output logic       o_multi_format
);
    import cidmd_pkg::*;

    logic full, push, q_valid, pop;
    t_rec front_rec, q_rec;

    cidmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_msg_byte (i_msg_byte),
        .i_full     (full),
        .o_push     (push),
        .o_rec      (front_rec)
    );

    cidmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_rec   (q_rec)
    );

    cidmd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_pop           (pop),
        .i_rec           (q_rec),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_char_value    (o_char_value),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_date_valid    (o_date_valid),
        .o_absent_reason (o_absent_reason),
        .o_checksum_ok   (o_checksum_ok),
        .o_multi_format  (o_multi_format)
    );

endmodule

// ===== src/cidmd_checker.sv =====
module cidmd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_msg_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_kind,
    input logic [7:0] o_char_value,
    input logic [6:0] o_month,
    input logic [6:0] o_day,
    input logic [6:0] o_hour,
    input logic [6:0] o_minute,
    input logic       o_date_valid,
    input logic [1:0] o_absent_reason,
    input logic       o_checksum_ok,
    input logic       o_multi_format
);
    import cidmd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_char_value))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_bad_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_BAD_TYPE |-> !o_multi_format && o_char_value == 8'd0)
        else $error("bad type word carries format or character");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_month <= 7'd99 && o_day <= 7'd99 && o_hour <= 7'd99
                    && o_minute <= 7'd99)
        else $error("date field out of range");

    a_no_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATE |-> o_month == 7'd0 && o_minute == 7'd0
                                          && !o_date_valid)
        else $error("date fields set on non-date word");

endmodule

bind caller_id_message_decoder_top cidmd_checker u_cidmd_checker (.*);
